### hdl/digit_count_priority_queue_core_defines.svh
// ----------------------------------------------------------------------------
// digit count priority queue assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef DIGIT_COUNT_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define DIGIT_COUNT_PRIORITY_QUEUE_CORE_DEFINES_SVH

// checked only outside reset
`define DCPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define DCPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hdl/dcpq_pkg.sv
// ----------------------------------------------------------------------------
// dcpq_pkg
// types, request codes and ranking helpers of the digit count priority queue
// ----------------------------------------------------------------------------
package dcpq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int FIFO_DEPTH          = 2;

  localparam int REQ_W   = 2;
  localparam int VALUE_W = 32;
  localparam int DIG_W   = 4;
  localparam int COUNT_W = 5;

  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PEEK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP  = 2'd2;

  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

  localparam logic [VALUE_W-2:0] POW10 [10] = '{
    31'd1, 31'd10, 31'd100, 31'd1000, 31'd10000, 31'd100000,
    31'd1000000, 31'd10000000, 31'd100000000, 31'd1000000000
  };

  typedef struct packed {
    logic [REQ_W-1:0]          req;
    logic signed [VALUE_W-1:0] value;
    logic [DIG_W-1:0]          digits;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] best_value;
    logic                      was_empty;
    logic                      push_rejected;
    logic [COUNT_W-1:0]        entry_count;
  } res_t;

  // decimal digit count, zero for non-positive values
  function automatic logic [DIG_W-1:0] digits_of(input logic signed [VALUE_W-1:0] v);
    logic [DIG_W-1:0] d;
    d = '0;
    if (!v[VALUE_W-1]) begin
      for (int k = 0; k < 10; k++) begin
        d = d + DIG_W'(v[VALUE_W-2:0] >= POW10[k]);
      end
    end
    return d;
  endfunction

  // a ranks strictly ahead of b
  function automatic logic better(input logic [DIG_W-1:0] a_dig,
                                  input logic signed [VALUE_W-1:0] a_val,
                                  input logic [DIG_W-1:0] b_dig,
                                  input logic signed [VALUE_W-1:0] b_val);
    return (a_dig < b_dig) || ((a_dig == b_dig) && (a_val > b_val));
  endfunction

endpackage

### hdl/dcpq_fifo.sv
// ----------------------------------------------------------------------------
// dcpq_fifo
// short decoupling queue between the classify front and the cell chain
// ----------------------------------------------------------------------------
module dcpq_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dcpq_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dcpq_pkg::item_t out_item_o
);
  import dcpq_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  item_t         mem_q [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          wr_en, rd_en;

  assign in_ready_o  = (cnt_q != CW'(FIFO_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign wr_en       = in_valid_i && in_ready_o;
  assign rd_en       = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

### hdl/dcpq_front.sv
// ----------------------------------------------------------------------------
// dcpq_front
// request intake stage, tags each beat with the digit count of its value
// ----------------------------------------------------------------------------
module dcpq_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    push,
  output logic                                    full,
  input  logic [dcpq_pkg::REQ_W-1:0]              req_type_i,
  input  logic signed [dcpq_pkg::VALUE_W-1:0]     value_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output dcpq_pkg::item_t                         out_item_o
);
  import dcpq_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;
  logic  accept;

  assign take        = !valid_q || out_ready_i;
  assign full        = !take;
  assign accept      = push && take;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d = accept;
    end
    if (accept) begin
      item_d.req    = req_type_i;
      item_d.value  = value_i;
      item_d.digits = digits_of(value_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

### hdl/dcpq_back.sv
// ----------------------------------------------------------------------------
// dcpq_back
// sorted cell chain, best entry in cell zero, and the result register
// ----------------------------------------------------------------------------
module dcpq_back #(
  parameter int QUEUE_DEPTH = dcpq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dcpq_pkg::item_t in_item_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output dcpq_pkg::res_t  res_o
);
  import dcpq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic signed [VALUE_W-1:0] val_q [QUEUE_DEPTH];
  logic signed [VALUE_W-1:0] val_d [QUEUE_DEPTH];
  logic [DIG_W-1:0]          dig_q [QUEUE_DEPTH];
  logic [DIG_W-1:0]          dig_d [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    valid_q, valid_d;

  logic signed [VALUE_W-1:0] up_val [QUEUE_DEPTH];
  logic [DIG_W-1:0]          up_dig [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    up_vld;
  logic [QUEUE_DEPTH-1:0]    up_gt;
  logic signed [VALUE_W-1:0] dn_val [QUEUE_DEPTH];
  logic [DIG_W-1:0]          dn_dig [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    dn_vld;
  logic [QUEUE_DEPTH-1:0]    gt;

  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW+COUNT_W-1:0] cnt_wide;
  res_t                  res_q, res_c;
  logic                  res_valid_q, res_valid_d;
  logic                  go;
  logic                  chain_full, chain_empty;

  assign in_ready_o  = !res_valid_q || res_ready_i;
  assign go          = in_valid_i && in_ready_o;
  assign chain_full  = valid_q[QUEUE_DEPTH-1];
  assign chain_empty = !valid_q[0];
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign gt[i] = !valid_q[i] ||
                   better(in_item_i.digits, in_item_i.value, dig_q[i], val_q[i]);
    if (i == 0) begin : g_head
      assign up_gt[i]  = 1'b0;
      assign up_val[i] = '0;
      assign up_dig[i] = '0;
      assign up_vld[i] = 1'b1;
    end else begin : g_body
      assign up_gt[i]  = gt[i-1];
      assign up_val[i] = val_q[i-1];
      assign up_dig[i] = dig_q[i-1];
      assign up_vld[i] = valid_q[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign dn_val[i] = '0;
      assign dn_dig[i] = '0;
      assign dn_vld[i] = 1'b0;
    end else begin : g_link
      assign dn_val[i] = val_q[i+1];
      assign dn_dig[i] = dig_q[i+1];
      assign dn_vld[i] = valid_q[i+1];
    end
  end

  always_comb begin
    val_d   = val_q;
    dig_d   = dig_q;
    valid_d = valid_q;
    cnt_d   = cnt_q;
    res_c   = '0;
    if (go) begin
      unique case (in_item_i.req) inside
        REQ_PUSH: begin
          if (chain_full) begin
            res_c.push_rejected = 1'b1;
          end else begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if (gt[i]) begin
                val_d[i] = up_gt[i] ? up_val[i] : in_item_i.value;
                dig_d[i] = up_gt[i] ? up_dig[i] : in_item_i.digits;
              end
              valid_d[i] = valid_q[i] || up_vld[i];
            end
            cnt_d = cnt_q + CW'(1);
          end
        end
        REQ_PEEK, REQ_POP: begin
          if (chain_empty) begin
            res_c.best_value = EMPTY_VALUE;
            res_c.was_empty  = 1'b1;
          end else begin
            res_c.best_value = val_q[0];
            if (in_item_i.req == REQ_POP) begin
              for (int i = 0; i < QUEUE_DEPTH; i++) begin
                val_d[i]   = dn_val[i];
                dig_d[i]   = dn_dig[i];
                valid_d[i] = dn_vld[i];
              end
              cnt_d = cnt_q - CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
    cnt_wide          = {{COUNT_W{1'b0}}, cnt_d};
    res_c.entry_count = cnt_wide[COUNT_W-1:0];
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (go) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    dig_q <= dig_d;
    if (go) begin
      res_q <= res_c;
    end
  end

endmodule

### hdl/digit_count_priority_queue_core.sv
// ----------------------------------------------------------------------------
// digit_count_priority_queue_core
// bounded priority queue, fewest decimal digits first, larger value on ties
// ----------------------------------------------------------------------------
// request side: drive req_type_i and value_i with push high; the beat is
// taken on a clock edge where full is low. codes: push value, peek, pop.
// result side: one result beat per request, in request order. while empty is
// low the oldest result is on best_value_o, was_empty_o, push_rejected_o and
// entry_count_o; it leaves on a clock edge where pop is high.
// path: a request taken at an edge passes the intake register and the
// two-entry decoupling queue; the cell chain stage registers its result.
// throughput: one request per cycle while pop stays high; the sorted cell
// chain inserts or shifts out its head in parallel; no scan over entries.
// stall: when pop stays low the result register holds, the chain stops, the
// queue fills and full rises after at most three more beats.
// reset: all cells are marked unused and the count clears at once; no
// clearing pass is needed, requests are taken right after reset.
// ----------------------------------------------------------------------------
module digit_count_priority_queue_core #(
  parameter int QUEUE_DEPTH = dcpq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [dcpq_pkg::REQ_W-1:0]          req_type_i,
  input  logic signed [dcpq_pkg::VALUE_W-1:0] value_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [dcpq_pkg::VALUE_W-1:0] best_value_o,
  output logic                                was_empty_o,
  output logic                                push_rejected_o,
  output logic [dcpq_pkg::COUNT_W-1:0]        entry_count_o
);
  import dcpq_pkg::*;

  item_t front_item, back_item;
  logic  front_valid, front_ready;
  logic  back_valid, back_ready;
  res_t  res;
  logic  res_valid;

  dcpq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_item_o  (front_item)
  );

  dcpq_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_item_i   (front_item),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready),
    .out_item_o  (back_item)
  );

  dcpq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (back_valid),
    .in_ready_o  (back_ready),
    .in_item_i   (back_item),
    .res_valid_o (res_valid),
    .res_ready_i (pop),
    .res_o       (res)
  );

  assign empty           = !res_valid;
  assign best_value_o    = res.best_value;
  assign was_empty_o     = res.was_empty;
  assign push_rejected_o = res.push_rejected;
  assign entry_count_o   = res.entry_count;

endmodule

### hdl/dcpq_checker.sv
// ----------------------------------------------------------------------------
// dcpq_checker
// port level checks of the digit count priority queue, bound to the top
// ----------------------------------------------------------------------------
`include "digit_count_priority_queue_core_defines.svh"

module dcpq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                empty,
  input logic                                pop,
  input logic signed [dcpq_pkg::VALUE_W-1:0] best_value_o,
  input logic                                was_empty_o,
  input logic                                push_rejected_o,
  input logic [dcpq_pkg::COUNT_W-1:0]        entry_count_o
);
  import dcpq_pkg::*;

  logic [VALUE_W+COUNT_W+1:0] res_beat;
  logic                       empty_read_ok;

  assign res_beat      = {best_value_o, was_empty_o, push_rejected_o, entry_count_o};
  assign empty_read_ok = (best_value_o == EMPTY_VALUE) && (entry_count_o == '0);

  // no result beat right after a reset edge
  `DCPQ_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> empty, "result shown during reset")

  // a stalled result beat holds
  `DCPQ_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(res_beat), "stalled result changed")

  // a beat cannot be both a rejected push and an empty read
  `DCPQ_ASSERT(a_flags, !empty |-> !(was_empty_o && push_rejected_o), "both flags set")

  // an empty read reports minus one and no entries
  `DCPQ_ASSERT(a_empty_read, !empty && was_empty_o |-> empty_read_ok, "bad empty read beat")

endmodule

bind digit_count_priority_queue_core dcpq_checker u_dcpq_checker (.*);
